FILE: rtl/scfp_pkg.sv
// types and constants shared by the sctp chunk field parser
package scfp_pkg;

  localparam int CountWidth = 5;

  // chunk type codes
  localparam logic [7:0] TYPE_DATA              = 8'd0;
  localparam logic [7:0] TYPE_INIT              = 8'd1;
  localparam logic [7:0] TYPE_INIT_ACK          = 8'd2;
  localparam logic [7:0] TYPE_SACK              = 8'd3;
  localparam logic [7:0] TYPE_HEARTBEAT         = 8'd4;
  localparam logic [7:0] TYPE_HEARTBEAT_ACK     = 8'd5;
  localparam logic [7:0] TYPE_ABORT             = 8'd6;
  localparam logic [7:0] TYPE_SHUTDOWN          = 8'd7;
  localparam logic [7:0] TYPE_SHUTDOWN_ACK      = 8'd8;
  localparam logic [7:0] TYPE_COOKIE_ECHO       = 8'd10;
  localparam logic [7:0] TYPE_COOKIE_ACK        = 8'd11;
  localparam logic [7:0] TYPE_SHUTDOWN_COMPLETE = 8'd14;

  // total byte counts (header plus value) needed per type
  localparam logic [CountWidth-1:0] HDR_BYTES  = 5'd4;
  localparam logic [CountWidth-1:0] INIT_TOTAL = 5'd20;
  localparam logic [CountWidth-1:0] DATA_TOTAL = 5'd16;
  localparam logic [CountWidth-1:0] SACK_TOTAL = 5'd16;
  localparam logic [CountWidth-1:0] COUNT_MAX  = 5'd31;

  // capture word selected by byte position bits [4:2]
  localparam logic [2:0] SLOT_HEADER = 3'd0;
  localparam logic [2:0] SLOT_A      = 3'd1;
  localparam logic [2:0] SLOT_B      = 3'd2;
  localparam logic [2:0] SLOT_C      = 3'd3;
  localparam logic [2:0] SLOT_D      = 3'd4;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_ERROR = 1'b1;

  typedef logic [CountWidth-1:0] count_t;

  // captured chunk words
  typedef struct packed {
    logic [31:0] header;
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [31:0] word_c;
    logic [31:0] word_d;
  } capture_t;

  // one decoded result item
  typedef struct packed {
    logic        parse_status;
    logic [7:0]  chunk_type;
    logic [7:0]  chunk_flags;
    logic [15:0] chunk_length;
    logic [31:0] first_word;
    logic [31:0] window_credit;
    logic [15:0] count_first;
    logic [15:0] count_second;
    logic [31:0] trailing_word;
  } result_t;

endpackage

FILE: rtl/scfp_if.sv
// valid/ready channel interfaces for chunk bytes and decoded results
interface scfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, data_byte, final_byte, input ready);
  modport sink (input valid, data_byte, final_byte, output ready);
endinterface

interface scfp_out_if;
  logic        valid;
  logic        ready;
  logic        parse_status;
  logic [7:0]  chunk_type;
  logic [7:0]  chunk_flags;
  logic [15:0] chunk_length;
  logic [31:0] first_word;
  logic [31:0] window_credit;
  logic [15:0] count_first;
  logic [15:0] count_second;
  logic [31:0] trailing_word;

  modport source (
    output valid, parse_status, chunk_type, chunk_flags, chunk_length,
           first_word, window_credit, count_first, count_second, trailing_word,
    input  ready
  );
  modport sink (
    input  valid, parse_status, chunk_type, chunk_flags, chunk_length,
           first_word, window_credit, count_first, count_second, trailing_word,
    output ready
  );
endinterface

FILE: rtl/scfp_decode.sv
// field decode of a captured chunk into one result item
module scfp_decode (
  input  scfp_pkg::count_t   byte_count,
  input  scfp_pkg::capture_t cap,
  output scfp_pkg::result_t  res
);

  logic [7:0] ctype;

  assign ctype = cap.header[31:24];

  // per type field selection
  always_comb begin
    res = '0;
    if (byte_count < scfp_pkg::HDR_BYTES) begin
      res.parse_status = scfp_pkg::STATUS_ERROR;
    end else begin
      res.chunk_type   = ctype;
      res.chunk_flags  = cap.header[23:16];
      res.chunk_length = cap.header[15:0];
      unique case (ctype)
        scfp_pkg::TYPE_INIT, scfp_pkg::TYPE_INIT_ACK: begin
          if (byte_count >= scfp_pkg::INIT_TOTAL) begin
            res.first_word    = cap.word_a;
            res.window_credit = cap.word_b;
            res.count_first   = cap.word_c[31:16];
            res.count_second  = cap.word_c[15:0];
            res.trailing_word = cap.word_d;
          end else begin
            res.parse_status = scfp_pkg::STATUS_ERROR;
          end
        end
        scfp_pkg::TYPE_DATA: begin
          if (byte_count >= scfp_pkg::DATA_TOTAL) begin
            res.first_word    = cap.word_a;
            res.count_first   = cap.word_b[31:16];
            res.count_second  = cap.word_b[15:0];
            res.trailing_word = cap.word_c;
          end else begin
            res.parse_status = scfp_pkg::STATUS_ERROR;
          end
        end
        scfp_pkg::TYPE_SACK: begin
          if (byte_count >= scfp_pkg::SACK_TOTAL) begin
            res.first_word    = cap.word_a;
            res.window_credit = cap.word_b;
            res.count_first   = cap.word_c[31:16];
            res.count_second  = cap.word_c[15:0];
          end else begin
            res.parse_status = scfp_pkg::STATUS_ERROR;
          end
        end
        // header-only types decode nothing more
        scfp_pkg::TYPE_HEARTBEAT, scfp_pkg::TYPE_HEARTBEAT_ACK,
        scfp_pkg::TYPE_ABORT, scfp_pkg::TYPE_SHUTDOWN,
        scfp_pkg::TYPE_SHUTDOWN_ACK, scfp_pkg::TYPE_COOKIE_ECHO,
        scfp_pkg::TYPE_COOKIE_ACK, scfp_pkg::TYPE_SHUTDOWN_COMPLETE: begin
          res.parse_status = scfp_pkg::STATUS_OK;
        end
        default: begin
          res.parse_status = scfp_pkg::STATUS_ERROR;
        end
      endcase
    end
  end

endmodule

FILE: rtl/sctp_chunk_field_parser.sv
// sctp chunk field parser top level: byte capture, decode and result register
// one byte item accepted per cycle; the chunk result appears in the cycle
// after the accepted final byte, from a result register decoupling the two sides
// throughput is one item per cycle; input ready drops only while a result waits
// reset (rst_n low, synchronous) clears the byte count and the result valid
// after each final byte the byte count restarts at zero for the next chunk
module sctp_chunk_field_parser (
  input  logic             clk,
  input  logic             rst_n,
  scfp_in_if.sink          in_ch,
  scfp_out_if.source       out_ch
);

  scfp_pkg::count_t   byte_count_r;
  scfp_pkg::count_t   byte_count_upd;
  scfp_pkg::capture_t cap_r;
  scfp_pkg::capture_t cap_upd;
  scfp_pkg::result_t  res_dec;
  scfp_pkg::result_t  res_r;
  logic               out_valid_r;
  logic               accept;
  logic [2:0]         slot;

  // input handshake: take a byte unless an untaken result blocks the register
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // byte position picks the capture word
  assign slot = byte_count_r[4:2];

  // shift the item byte into its capture word and bump the saturating count
  always_comb begin
    cap_upd = cap_r;
    unique case (slot)
      scfp_pkg::SLOT_HEADER: cap_upd.header = {cap_r.header[23:0], in_ch.data_byte};
      scfp_pkg::SLOT_A:      cap_upd.word_a = {cap_r.word_a[23:0], in_ch.data_byte};
      scfp_pkg::SLOT_B:      cap_upd.word_b = {cap_r.word_b[23:0], in_ch.data_byte};
      scfp_pkg::SLOT_C:      cap_upd.word_c = {cap_r.word_c[23:0], in_ch.data_byte};
      scfp_pkg::SLOT_D:      cap_upd.word_d = {cap_r.word_d[23:0], in_ch.data_byte};
      default:               cap_upd = cap_r;
    endcase
    if (byte_count_r == scfp_pkg::COUNT_MAX) begin
      byte_count_upd = scfp_pkg::COUNT_MAX;
    end else begin
      byte_count_upd = byte_count_r + 5'd1;
    end
  end

  // decode from the state as it stands after this byte
  scfp_decode u_decode (
    .byte_count (byte_count_upd),
    .cap        (cap_upd),
    .res        (res_dec)
  );

  // byte count and capture words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
    end else if (accept) begin
      byte_count_r <= in_ch.final_byte ? '0 : byte_count_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cap_r <= cap_upd;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && in_ch.final_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_ch.final_byte) begin
      res_r <= res_dec;
    end
  end

  // result channel
  assign out_ch.valid         = out_valid_r;
  assign out_ch.parse_status  = res_r.parse_status;
  assign out_ch.chunk_type    = res_r.chunk_type;
  assign out_ch.chunk_flags   = res_r.chunk_flags;
  assign out_ch.chunk_length  = res_r.chunk_length;
  assign out_ch.first_word    = res_r.first_word;
  assign out_ch.window_credit = res_r.window_credit;
  assign out_ch.count_first   = res_r.count_first;
  assign out_ch.count_second  = res_r.count_second;
  assign out_ch.trailing_word = res_r.trailing_word;

endmodule

FILE: sim/tb_sctp_chunk_field_parser.sv
// self-checking testbench for the sctp chunk field parser: stimulus, prediction, checks
module tb_sctp_chunk_field_parser;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 200000;
  localparam int RandomItems = 700;
  localparam int DrainCycles = 20;
  localparam int MaxPrinted = 40;

  // one chunk byte waiting to be driven
  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         hold;
  } byte_item_t;

  logic clk;
  logic rst_n;

  scfp_in_if  in_if ();
  scfp_out_if out_if ();

  sctp_chunk_field_parser u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  byte_item_t          pending_bytes_q[$];
  scfp_pkg::result_t   chunk_results_q[$];

  // predictor copy of the capture state
  scfp_pkg::count_t seen_count;
  logic [31:0] hdr_word;
  logic [31:0] word_a;
  logic [31:0] word_b;
  logic [31:0] word_c;
  logic [31:0] word_d;

  int total_items;
  int bytes_sent;
  int chunks_predicted;
  int error_chunks;
  int chunks_received;
  int mismatch_count;
  int phase;

  byte_item_t        drv_item;
  scfp_pkg::result_t drv_result;
  scfp_pkg::result_t mon_want;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("tb_sctp_chunk_field_parser: errors");
    $finish;
  end

  // capture one byte and decode the chunk on its last byte
  function automatic bit chunk_decode(input logic [7:0] b, input logic last,
                                      output scfp_pkg::result_t dec);
    scfp_pkg::count_t total;
    logic [7:0] ty;
    dec = '0;
    case (seen_count[4:2])
      scfp_pkg::SLOT_HEADER: hdr_word = {hdr_word[23:0], b};
      scfp_pkg::SLOT_A:      word_a   = {word_a[23:0], b};
      scfp_pkg::SLOT_B:      word_b   = {word_b[23:0], b};
      scfp_pkg::SLOT_C:      word_c   = {word_c[23:0], b};
      scfp_pkg::SLOT_D:      word_d   = {word_d[23:0], b};
      default: ;
    endcase
    total = (seen_count == scfp_pkg::COUNT_MAX) ? scfp_pkg::COUNT_MAX : seen_count + 1'b1;
    seen_count = total;
    if (!last) return 1'b0;

    if (total < scfp_pkg::HDR_BYTES) begin
      dec.parse_status = scfp_pkg::STATUS_ERROR;
    end else begin
      ty = hdr_word[31:24];
      dec.parse_status = scfp_pkg::STATUS_OK;
      dec.chunk_type   = ty;
      dec.chunk_flags  = hdr_word[23:16];
      dec.chunk_length = hdr_word[15:0];
      case (ty)
        scfp_pkg::TYPE_INIT, scfp_pkg::TYPE_INIT_ACK: begin
          if (total >= scfp_pkg::INIT_TOTAL) begin
            dec.first_word    = word_a;
            dec.window_credit = word_b;
            dec.count_first   = word_c[31:16];
            dec.count_second  = word_c[15:0];
            dec.trailing_word = word_d;
          end else begin
            dec.parse_status = scfp_pkg::STATUS_ERROR;
          end
        end
        scfp_pkg::TYPE_DATA: begin
          if (total >= scfp_pkg::DATA_TOTAL) begin
            dec.first_word    = word_a;
            dec.count_first   = word_b[31:16];
            dec.count_second  = word_b[15:0];
            dec.trailing_word = word_c;
          end else begin
            dec.parse_status = scfp_pkg::STATUS_ERROR;
          end
        end
        scfp_pkg::TYPE_SACK: begin
          if (total >= scfp_pkg::SACK_TOTAL) begin
            dec.first_word    = word_a;
            dec.window_credit = word_b;
            dec.count_first   = word_c[31:16];
            dec.count_second  = word_c[15:0];
          end else begin
            dec.parse_status = scfp_pkg::STATUS_ERROR;
          end
        end
        scfp_pkg::TYPE_HEARTBEAT, scfp_pkg::TYPE_HEARTBEAT_ACK, scfp_pkg::TYPE_ABORT,
        scfp_pkg::TYPE_SHUTDOWN, scfp_pkg::TYPE_SHUTDOWN_ACK, scfp_pkg::TYPE_COOKIE_ECHO,
        scfp_pkg::TYPE_COOKIE_ACK, scfp_pkg::TYPE_SHUTDOWN_COMPLETE: ;
        default: dec.parse_status = scfp_pkg::STATUS_ERROR;
      endcase
    end

    // next byte starts a new chunk
    seen_count = '0;
    hdr_word   = '0;
    word_a     = '0;
    word_b     = '0;
    word_c     = '0;
    word_d     = '0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < MaxPrinted)
      $display("mismatch chunk %0d %s: got %0h expected %0h",
               chunks_received, what, got, want);
    mismatch_count++;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic last, input bit hold);
    byte_item_t it;
    it.data = b;
    it.last = last;
    it.hold = hold;
    pending_bytes_q.push_back(it);
  endtask

  // queue a chunk: header bytes first, then random value bytes
  task automatic push_chunk(input logic [7:0] ty, input logic [7:0] flags,
                            input logic [15:0] len, input int nbytes, input bit hold);
    logic [7:0] b;
    int sel;
    for (int i = 0; i < nbytes; i++) begin
      sel = $urandom_range(15);
      case (i)
        0: b = ty;
        1: b = flags;
        2: b = len[15:8];
        3: b = len[7:0];
        default: b = (sel == 0) ? 8'h00 : (sel == 1) ? 8'hff : 8'($urandom_range(255));
      endcase
      push_byte(b, i == nbytes - 1, hold && i == 0);
    end
  endtask

  // random well-formed chunks, with short, long and unknown ones mixed in
  task automatic push_random_chunk(input bit hold);
    logic [7:0] ty;
    logic [15:0] len;
    int need;
    int nbytes;
    int r;
    r = $urandom_range(99);
    if (r < 75) begin
      case ($urandom_range(11))
        0: ty = scfp_pkg::TYPE_DATA;
        1: ty = scfp_pkg::TYPE_INIT;
        2: ty = scfp_pkg::TYPE_INIT_ACK;
        3: ty = scfp_pkg::TYPE_SACK;
        4: ty = scfp_pkg::TYPE_HEARTBEAT;
        5: ty = scfp_pkg::TYPE_HEARTBEAT_ACK;
        6: ty = scfp_pkg::TYPE_ABORT;
        7: ty = scfp_pkg::TYPE_SHUTDOWN;
        8: ty = scfp_pkg::TYPE_SHUTDOWN_ACK;
        9: ty = scfp_pkg::TYPE_COOKIE_ECHO;
        10: ty = scfp_pkg::TYPE_COOKIE_ACK;
        default: ty = scfp_pkg::TYPE_SHUTDOWN_COMPLETE;
      endcase
    end else begin
      ty = 8'($urandom_range(255));
    end
    case (ty)
      scfp_pkg::TYPE_INIT, scfp_pkg::TYPE_INIT_ACK: need = int'(scfp_pkg::INIT_TOTAL);
      scfp_pkg::TYPE_DATA:                          need = int'(scfp_pkg::DATA_TOTAL);
      scfp_pkg::TYPE_SACK:                          need = int'(scfp_pkg::SACK_TOTAL);
      default:                                      need = int'(scfp_pkg::HDR_BYTES);
    endcase
    r = $urandom_range(99);
    if (r < 55)      nbytes = need;
    else if (r < 70) nbytes = $urandom_range(need - 1, 1);
    else if (r < 88) nbytes = need + $urandom_range(4, 1);
    else             nbytes = $urandom_range(40, 21);
    len = ($urandom_range(1) == 0) ? 16'(nbytes) : 16'($urandom_range(65535));
    push_chunk(ty, 8'($urandom_range(255)), len, nbytes, hold);
  endtask

  // stimulus, reset and end of run
  initial begin
    bit mark_first;
    bit mark_second;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.data_byte = 8'h00;
    in_if.final_byte = 1'b0;
    out_if.ready = 1'b0;
    seen_count = '0;
    hdr_word = '0;
    word_a = '0;
    word_b = '0;
    word_c = '0;
    word_d = '0;
    total_items = 0;
    bytes_sent = 0;
    chunks_predicted = 0;
    error_chunks = 0;
    chunks_received = 0;
    mismatch_count = 0;
    phase = 0;
    mark_first = 1'b0;
    mark_second = 1'b0;

    // short header
    push_byte(8'hff, 1'b0, 1'b0);
    push_byte(8'h00, 1'b1, 1'b0);
    // header-only type with all-ones flags and length
    push_chunk(scfp_pkg::TYPE_SHUTDOWN_COMPLETE, 8'hff, 16'hffff, 4, 1'b0);
    // unknown type
    push_chunk(8'hff, 8'h00, 16'h0000, 4, 1'b0);
    // data chunk one byte short of its value
    push_chunk(scfp_pkg::TYPE_DATA, 8'h00, 16'h0010, 15, 1'b0);

    while (pending_bytes_q.size() < RandomItems + 25) begin
      if (!mark_first && pending_bytes_q.size() > (RandomItems + 25) / 3) begin
        mark_first = 1'b1;
        push_random_chunk(1'b1);
      end else if (!mark_second && pending_bytes_q.size() > 2 * (RandomItems + 25) / 3) begin
        mark_second = 1'b1;
        push_random_chunk(1'b1);
      end else begin
        push_random_chunk($urandom_range(19) == 0);
      end
    end
    total_items = pending_bytes_q.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // wait for all bytes, then for every decoded chunk
    while (bytes_sent < total_items) @(posedge clk);
    while (chunks_received < chunks_predicted) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (chunk_results_q.size() != 0) begin
      report_mismatch("results never came out", 32'(chunk_results_q.size()), 32'd0);
    end

    $display("covered %0d byte items in %0d chunks, %0d of them decoded with error status",
             bytes_sent, chunks_predicted, error_chunks);
    $display("%0d chunk results checked, %0d mismatches", chunks_received, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb_sctp_chunk_field_parser: clean");
    end else begin
      $display("tb_sctp_chunk_field_parser: errors");
    end
    $finish;
  end

  // byte driver: predicts on each accepted item, then offers the next one
  always @(posedge clk) begin
    int send_idle;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        if (chunk_decode(in_if.data_byte, in_if.final_byte, drv_result)) begin
          chunk_results_q.push_back(drv_result);
          chunks_predicted++;
          if (drv_result.parse_status == scfp_pkg::STATUS_ERROR) error_chunks++;
        end
        bytes_sent++;
      end
      phase <= (bytes_sent < total_items / 3) ? 0 : (bytes_sent < 2 * total_items / 3) ? 1 : 2;
      send_idle = (phase == 0) ? 27 : (phase == 1) ? 47 : 0;
      if (!in_if.valid || in_if.ready) begin
        // a held item waits until every decoded chunk has been taken
        if (pending_bytes_q.size() > 0 &&
            !(pending_bytes_q[0].hold && chunks_predicted != chunks_received) &&
            $urandom_range(99) >= send_idle) begin
          drv_item = pending_bytes_q.pop_front();
          in_if.valid      <= 1'b1;
          in_if.data_byte  <= drv_item.data;
          in_if.final_byte <= drv_item.last;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: compares each taken item with the oldest prediction
  always @(posedge clk) begin
    int recv_idle;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        chunks_received <= chunks_received + 1;
        if (chunk_results_q.size() == 0) begin
          report_mismatch("unexpected result", {31'd0, out_if.parse_status}, 32'd0);
        end else begin
          mon_want = chunk_results_q.pop_front();
          if (out_if.parse_status !== mon_want.parse_status)
            report_mismatch("parse_status", 32'(out_if.parse_status),
                            32'(mon_want.parse_status));
          if (out_if.chunk_type !== mon_want.chunk_type)
            report_mismatch("chunk_type", 32'(out_if.chunk_type), 32'(mon_want.chunk_type));
          if (out_if.chunk_flags !== mon_want.chunk_flags)
            report_mismatch("chunk_flags", 32'(out_if.chunk_flags),
                            32'(mon_want.chunk_flags));
          if (out_if.chunk_length !== mon_want.chunk_length)
            report_mismatch("chunk_length", 32'(out_if.chunk_length),
                            32'(mon_want.chunk_length));
          if (out_if.first_word !== mon_want.first_word)
            report_mismatch("first_word", out_if.first_word, mon_want.first_word);
          if (out_if.window_credit !== mon_want.window_credit)
            report_mismatch("window_credit", out_if.window_credit, mon_want.window_credit);
          if (out_if.count_first !== mon_want.count_first)
            report_mismatch("count_first", 32'(out_if.count_first),
                            32'(mon_want.count_first));
          if (out_if.count_second !== mon_want.count_second)
            report_mismatch("count_second", 32'(out_if.count_second),
                            32'(mon_want.count_second));
          if (out_if.trailing_word !== mon_want.trailing_word)
            report_mismatch("trailing_word", out_if.trailing_word, mon_want.trailing_word);
        end
      end
      recv_idle = (phase == 0) ? 47 : (phase == 1) ? 27 : 0;
      out_if.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

endmodule

FILE: files.f
rtl/scfp_pkg.sv
rtl/scfp_if.sv
rtl/scfp_decode.sv
rtl/sctp_chunk_field_parser.sv
sim/tb_sctp_chunk_field_parser.sv
